>>> rtl/core/pds_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and types for the PLL divider search.
package pds_pkg;

  localparam int FB_DIV_MAX_DEF   = 320;
  localparam int FB_DIV_MIN       = 16;
  localparam int POST_DIV_MAX_DEF = 7;

  localparam int REF_W      = 26;
  localparam int VCO_REG_W  = 31;
  localparam int TGT_W      = 32;
  localparam int FREQ_W     = 31;
  localparam int PDIV_OUT_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MAX   = 2'd2;

  localparam logic [REF_W-1:0]     REFERENCE_RST = 26'd12000000;
  localparam logic [VCO_REG_W-1:0] VCO_MIN_RST   = 31'd750000000;
  localparam logic [VCO_REG_W-1:0] VCO_MAX_RST   = 31'd1600000000;

  // Sequencer to datapath control
  typedef struct packed {
    logic start;
    logic issue;
  } seq_ctl_t;

  // Best candidate so far, already in output widths
  typedef struct packed {
    logic                  found;
    logic [FREQ_W-1:0]     achieved;
    logic [VCO_REG_W-1:0]  vco;
    logic [PDIV_OUT_W-1:0] p1;
    logic [PDIV_OUT_W-1:0] p2;
    logic [TGT_W-1:0]      err;
  } result_t;

endpackage

>>> rtl/core/pds_seq.sv
`timescale 1ns / 1ps
// Search sequencer: walks feedback dividers, checks the VCO window, issues divider pairs.
module pds_seq #(
  parameter int FB_DIV_MAX   = pds_pkg::FB_DIV_MAX_DEF,
  parameter int POST_DIV_MAX = pds_pkg::POST_DIV_MAX_DEF,
  localparam int FB_W = $clog2(FB_DIV_MAX + 1),
  localparam int P_W  = $clog2(POST_DIV_MAX + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pds_pkg::REF_W-1:0]        reference_hz,
  input  logic [pds_pkg::VCO_REG_W-1:0]    vco_min_hz,
  input  logic [pds_pkg::VCO_REG_W-1:0]    vco_max_hz,
  input  logic                             pipe_busy,
  input  logic                             out_free,
  output pds_pkg::seq_ctl_t                ctl,
  output logic                             idle,
  output logic                             done_load,
  output logic [pds_pkg::VCO_REG_W-1:0]    cand_vco,
  output logic [P_W-1:0]                   cand_p1,
  output logic [P_W-1:0]                   cand_p2
);
  import pds_pkg::*;

  localparam int VCO_W = FB_W + REF_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_CHECK = 6'b000100,
    S_PAIR  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [FB_W-1:0]   fb, fb_next;
  logic [P_W-1:0]    p1, p1_next;
  logic [P_W-1:0]    p2, p2_next;
  logic [VCO_W-1:0]  vco;
  logic              in_window;
  logic              last_fb;

  assign in_window = (vco >= VCO_W'(vco_min_hz)) && (vco <= VCO_W'(vco_max_hz));
  assign last_fb   = (fb == FB_W'(FB_DIV_MIN));

  always_comb begin
    state_next = state;
    fb_next    = fb;
    p1_next    = p1;
    p2_next    = p2;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_MUL;
          fb_next    = FB_W'(FB_DIV_MAX);
        end
      end
      S_MUL: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (in_window) begin
          state_next = S_PAIR;
          p1_next    = P_W'(POST_DIV_MAX);
          p2_next    = P_W'(POST_DIV_MAX);
        end else if (last_fb) begin
          state_next = S_DRAIN;
        end else begin
          fb_next    = fb - FB_W'(1);
          state_next = S_MUL;
        end
      end
      S_PAIR: begin
        if (p2 == P_W'(1)) begin
          if (p1 == P_W'(1)) begin
            if (last_fb) begin
              state_next = S_DRAIN;
            end else begin
              fb_next    = fb - FB_W'(1);
              state_next = S_MUL;
            end
          end else begin
            p1_next = p1 - P_W'(1);
            p2_next = p1 - P_W'(1);
          end
        end else begin
          p2_next = p2 - P_W'(1);
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fb    <= '0;
      p1    <= '0;
      p2    <= '0;
    end else begin
      state <= state_next;
      fb    <= fb_next;
      p1    <= p1_next;
      p2    <= p2_next;
    end
  end

  // VCO product for the current feedback divider
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      vco <= fb * reference_hz;
    end
  end

  assign ctl.start = start && (state == S_IDLE);
  assign ctl.issue = (state == S_PAIR);
  assign idle      = (state == S_IDLE);
  assign done_load = (state == S_DONE) && out_free;
  assign cand_vco  = vco[VCO_REG_W-1:0];
  assign cand_p1   = p1;
  assign cand_p2   = p2;

endmodule

>>> rtl/core/pds_div.sv
`timescale 1ns / 1ps
// Shared divide unit: VCO over post-divider product by reciprocal multiply and correction.
module pds_div #(
  parameter int POST_DIV_MAX = pds_pkg::POST_DIV_MAX_DEF,
  localparam int P_W  = $clog2(POST_DIV_MAX + 1),
  localparam int DMAX = POST_DIV_MAX * POST_DIV_MAX,
  localparam int D_W  = $clog2(DMAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pds_pkg::seq_ctl_t             ctl,
  input  logic [pds_pkg::VCO_REG_W-1:0] vco,
  input  logic [P_W-1:0]                p1,
  input  logic [P_W-1:0]                p2,
  output logic                          res_valid,
  output logic [pds_pkg::FREQ_W-1:0]    res_freq,
  output logic [pds_pkg::VCO_REG_W-1:0] res_vco,
  output logic [P_W-1:0]                res_p1,
  output logic [P_W-1:0]                res_p2,
  output logic                          busy
);
  import pds_pkg::*;

  localparam int NSTG = 5;
  localparam int QD_W = VCO_REG_W + D_W;
  localparam int PR_W = VCO_REG_W + 32;

  logic [NSTG-1:0]      v;
  logic [VCO_REG_W-1:0] vco_s [NSTG];
  logic [P_W-1:0]       p1_s  [NSTG];
  logic [P_W-1:0]       p2_s  [NSTG];

  logic [31:0]          recip [2**D_W];
  logic [D_W-1:0]       d1, d2, d3, d4;
  logic [31:0]          m2;
  logic [PR_W-1:0]      prod;
  logic [FREQ_W-1:0]    q3, q4, freq5;
  logic [QD_W-1:0]      qd4;
  logic [QD_W-1:0]      rem;

  // floor(2^32 / d), clamped to 32 bits; quotient estimate is then exact or one low
  for (genvar gd = 0; gd < 2**D_W; gd++) begin : g_recip
    localparam logic [32:0] FULL = 33'h1_0000_0000 / ((gd == 0) ? 1 : gd);
    localparam logic [31:0] M    = (FULL > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : FULL[31:0];
    assign recip[gd] = M;
  end

  assign prod = PR_W'(vco_s[1]) * PR_W'(m2);
  assign rem  = QD_W'(vco_s[3]) - qd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[NSTG-2:0], ctl.issue};
    end
  end

  always_ff @(posedge clk) begin
    vco_s[0] <= vco;
    p1_s[0]  <= p1;
    p2_s[0]  <= p2;
    for (int i = 1; i < NSTG; i++) begin
      vco_s[i] <= vco_s[i-1];
      p1_s[i]  <= p1_s[i-1];
      p2_s[i]  <= p2_s[i-1];
    end
    d1    <= D_W'(p1) * D_W'(p2);
    m2    <= recip[d1];
    d2    <= d1;
    q3    <= prod[PR_W-1:32];
    d3    <= d2;
    qd4   <= QD_W'(q3) * QD_W'(d3);
    q4    <= q3;
    d4    <= d3;
    freq5 <= (rem >= QD_W'(d4)) ? (q4 + FREQ_W'(1)) : q4;
  end

  assign res_valid = v[NSTG-1];
  assign res_freq  = freq5;
  assign res_vco   = vco_s[NSTG-1];
  assign res_p1    = p1_s[NSTG-1];
  assign res_p2    = p2_s[NSTG-1];
  assign busy      = |v;

endmodule

>>> rtl/core/pds_best.sv
`timescale 1ns / 1ps
// Error stage and best-candidate tracking.
module pds_best #(
  parameter int POST_DIV_MAX = pds_pkg::POST_DIV_MAX_DEF,
  localparam int P_W = $clog2(POST_DIV_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pds_pkg::seq_ctl_t             ctl,
  input  logic [pds_pkg::TGT_W-1:0]     target_hz,
  input  logic                          cand_valid,
  input  logic [pds_pkg::FREQ_W-1:0]    cand_freq,
  input  logic [pds_pkg::VCO_REG_W-1:0] cand_vco,
  input  logic [P_W-1:0]                cand_p1,
  input  logic [P_W-1:0]                cand_p2,
  output pds_pkg::result_t              best,
  output logic                          busy
);
  import pds_pkg::*;

  logic [TGT_W-1:0]     target_r;
  logic [TGT_W-1:0]     freq_ext;
  logic                 e_valid;
  logic [TGT_W-1:0]     e_err;
  logic [FREQ_W-1:0]    e_freq;
  logic [VCO_REG_W-1:0] e_vco;
  logic [P_W-1:0]       e_p1, e_p2;
  logic                 take;

  assign freq_ext = TGT_W'(cand_freq);
  // strictly smaller error wins, so the earliest of equals stays
  assign take     = e_valid && (!best.found || (e_err < best.err));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      target_r <= target_hz;
    end
    e_err  <= (freq_ext >= target_r) ? (freq_ext - target_r) : (target_r - freq_ext);
    e_freq <= cand_freq;
    e_vco  <= cand_vco;
    e_p1   <= cand_p1;
    e_p2   <= cand_p2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid    <= 1'b0;
      best.found <= 1'b0;
    end else begin
      e_valid <= cand_valid;
      if (ctl.start) begin
        best <= '0;
      end else if (take) begin
        best.found    <= 1'b1;
        best.achieved <= e_freq;
        best.vco      <= e_vco;
        best.p1       <= PDIV_OUT_W'(e_p1);
        best.p2       <= PDIV_OUT_W'(e_p2);
        best.err      <= e_err;
      end
    end
  end

  assign busy = e_valid;

endmodule

>>> rtl/core/pll_divider_search.sv
`timescale 1ns / 1ps
// Top level of the PLL feedback and post-divider search.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  config   | cfg_write                 | cfg_index, cfg_data
//  request  | in_valid / in_stall       | target_hz
//  result   | out_valid / out_stall     | found, achieved_hz, vco_hz, first_post_div,
//           |                           | second_post_div, error_hz
//
// One transaction in gives one transaction out. For each feedback value (FB_DIV_MAX down
// to FB_DIV_MIN) the search forms the VCO product and checks it against the VCO window;
// for a value inside the window it issues every post-divider pair (first >= second)
// through the shared divide unit, and at the end it waits for the pipeline to drain.
// Defaults: 305 feedback values and 28 post-divider pairs per value in the window.
// Synchronous reset restores the register defaults and empties the search.
// The request side is stalled while a search runs; a finished result sits in the
// output register, so a new request is taken while that result is still stalled.
module pll_divider_search #(
  parameter int FB_DIV_MAX   = pds_pkg::FB_DIV_MAX_DEF,
  parameter int POST_DIV_MAX = pds_pkg::POST_DIV_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pds_pkg::TGT_W-1:0]      target_hz,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [pds_pkg::FREQ_W-1:0]     achieved_hz,
  output logic [pds_pkg::VCO_REG_W-1:0]  vco_hz,
  output logic [pds_pkg::PDIV_OUT_W-1:0] first_post_div,
  output logic [pds_pkg::PDIV_OUT_W-1:0] second_post_div,
  output logic [pds_pkg::TGT_W-1:0]      error_hz
);
  import pds_pkg::*;

  localparam int P_W = $clog2(POST_DIV_MAX + 1);

  // configuration registers
  logic [REF_W-1:0]     ref_hz;
  logic [VCO_REG_W-1:0] vco_min;
  logic [VCO_REG_W-1:0] vco_max;

  seq_ctl_t             ctl;
  logic                 seq_idle;
  logic                 done_load;
  logic                 in_accept;
  logic                 out_free;
  logic                 pipe_busy;
  logic                 div_busy;
  logic                 best_busy;

  logic [VCO_REG_W-1:0] cand_vco;
  logic [P_W-1:0]       cand_p1, cand_p2;

  logic                 div_valid;
  logic [FREQ_W-1:0]    div_freq;
  logic [VCO_REG_W-1:0] div_vco;
  logic [P_W-1:0]       div_p1, div_p2;

  result_t              best;
  result_t              res;

  // drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_hz  <= REFERENCE_RST;
      vco_min <= VCO_MIN_RST;
      vco_max <= VCO_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REFERENCE: ref_hz  <= cfg_data[REF_W-1:0];
        REG_VCO_MIN:   vco_min <= cfg_data;
        REG_VCO_MAX:   vco_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // hold off requests while a search runs or during reset
  assign in_stall  = rst || !seq_idle;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign pipe_busy = div_busy || best_busy;

  pds_seq #(
    .FB_DIV_MAX   (FB_DIV_MAX),
    .POST_DIV_MAX (POST_DIV_MAX)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (in_accept),
    .reference_hz (ref_hz),
    .vco_min_hz   (vco_min),
    .vco_max_hz   (vco_max),
    .pipe_busy    (pipe_busy),
    .out_free     (out_free),
    .ctl          (ctl),
    .idle         (seq_idle),
    .done_load    (done_load),
    .cand_vco     (cand_vco),
    .cand_p1      (cand_p1),
    .cand_p2      (cand_p2)
  );

  pds_div #(
    .POST_DIV_MAX (POST_DIV_MAX)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .vco       (cand_vco),
    .p1        (cand_p1),
    .p2        (cand_p2),
    .res_valid (div_valid),
    .res_freq  (div_freq),
    .res_vco   (div_vco),
    .res_p1    (div_p1),
    .res_p2    (div_p2),
    .busy      (div_busy)
  );

  pds_best #(
    .POST_DIV_MAX (POST_DIV_MAX)
  ) u_best (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .target_hz  (target_hz),
    .cand_valid (div_valid),
    .cand_freq  (div_freq),
    .cand_vco   (div_vco),
    .cand_p1    (div_p1),
    .cand_p2    (div_p2),
    .best       (best),
    .busy       (best_busy)
  );

  // output register: load the finished search, release on a taken transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      res <= best;
    end
  end

  assign found           = res.found;
  assign achieved_hz     = res.achieved;
  assign vco_hz          = res.vco;
  assign first_post_div  = res.p1;
  assign second_post_div = res.p2;
  assign error_hz        = res.err;

  // a request always starts a search that blocks the next one
  a_accept_blocks : assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("request taken while a search was starting");

  // candidates only flow during a search
  a_issue_busy : assert property (@(posedge clk) disable iff (rst)
    ctl.issue |-> in_stall)
    else $error("candidate issued while idle");

  // result must not be captured before the datapath has drained
  a_load_drained : assert property (@(posedge clk) disable iff (rst)
    done_load |-> !pipe_busy)
    else $error("result loaded with candidates still in flight");

  // an empty search reports all-zero fields
  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (achieved_hz == '0 && vco_hz == '0 && error_hz == '0))
    else $error("empty search returned non-zero fields");

endmodule
